// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SMPC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SMPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/smpc_pkg.sv -----
// ----------------------------------------------------------------------------
// smpc_pkg
// Widths, codes and the control store of the sliding mode position controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smpc_pkg;

	// field and register widths
	localparam int IN_W    = 32;
	localparam int OUT_W   = 32;
	localparam int GAIN_W  = 31;
	localparam int IDX_W   = 3;
	localparam int DELTA_W = 33;
	localparam int ERR_W   = 33;
	localparam int VERR_W  = 34;
	localparam int DDREF_W = 34;
	localparam int S_W     = 49;
	localparam int BR_W    = 65;
	localparam int LIMB_W  = 33;
	localparam int PROD_W  = 65;
	localparam int ACC_W   = 98;
	localparam int SH_W    = ACC_W - 16;
	localparam int SAT_W   = 18;
	localparam int PC_W    = 4;

	localparam logic [PC_W-1:0] LAST_PC = PC_W'(11);

	// boundary layer limit, 1.0 in Q1.16
	localparam logic signed [SAT_W-1:0] ONE_Q16 = SAT_W'(65536);

	// register indexes
	localparam logic [IDX_W-1:0] CFG_SLOPE    = 3'd0;
	localparam logic [IDX_W-1:0] CFG_REACH    = 3'd1;
	localparam logic [IDX_W-1:0] CFG_SWITCH   = 3'd2;
	localparam logic [IDX_W-1:0] CFG_INERTIA  = 3'd3;
	localparam logic [IDX_W-1:0] CFG_DEADBAND = 3'd4;
	localparam logic [IDX_W-1:0] CFG_MAX_OUT  = 3'd5;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_LO,
		MUL_HI
	} mul_op_t;

	typedef enum logic [1:0] {
		G_SLOPE,
		G_REACH,
		G_SWITCH,
		G_INERTIA
	} gain_sel_t;

	typedef enum logic [2:0] {
		O_ERR,
		O_VERR,
		O_S,
		O_SAT,
		O_BR
	} opnd_sel_t;

	typedef enum logic [2:0] {
		WB_NONE,
		WB_S,
		WB_BR_INIT,
		WB_BR_SUB,
		WB_DRIVE
	} wb_t;

	typedef enum logic {
		JMP_NONE,
		JMP_DEAD
	} jmp_t;

	typedef struct packed {
		mul_op_t   mul;
		gain_sel_t gain;
		opnd_sel_t opnd;
		wb_t       wb;
		jmp_t      jmp;
		logic      last;
	} ucode_t;

	// control store: one word per step
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '{MUL_NONE, G_SLOPE, O_ERR, WB_NONE, JMP_NONE, 1'b0};
		unique case (pc)
			4'd0:  w = '{MUL_LO,   G_SLOPE,   O_ERR,  WB_NONE,    JMP_DEAD, 1'b0};
			4'd1:  w = '{MUL_HI,   G_SLOPE,   O_ERR,  WB_NONE,    JMP_NONE, 1'b0};
			4'd2:  w = '{MUL_LO,   G_SLOPE,   O_VERR, WB_S,       JMP_NONE, 1'b0};
			4'd3:  w = '{MUL_HI,   G_SLOPE,   O_VERR, WB_NONE,    JMP_NONE, 1'b0};
			4'd4:  w = '{MUL_LO,   G_REACH,   O_S,    WB_BR_INIT, JMP_NONE, 1'b0};
			4'd5:  w = '{MUL_HI,   G_REACH,   O_S,    WB_NONE,    JMP_NONE, 1'b0};
			4'd6:  w = '{MUL_LO,   G_SWITCH,  O_SAT,  WB_BR_SUB,  JMP_NONE, 1'b0};
			4'd7:  w = '{MUL_HI,   G_SWITCH,  O_SAT,  WB_NONE,    JMP_NONE, 1'b0};
			4'd8:  w = '{MUL_NONE, G_SLOPE,   O_ERR,  WB_BR_SUB,  JMP_NONE, 1'b0};
			4'd9:  w = '{MUL_LO,   G_INERTIA, O_BR,   WB_NONE,    JMP_NONE, 1'b0};
			4'd10: w = '{MUL_HI,   G_INERTIA, O_BR,   WB_NONE,    JMP_NONE, 1'b0};
			4'd11: w = '{MUL_NONE, G_SLOPE,   O_ERR,  WB_DRIVE,   JMP_NONE, 1'b1};
			default: w = '{MUL_NONE, G_SLOPE, O_ERR,  WB_NONE,    JMP_NONE, 1'b1};
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/core/sliding_mode_position_controller.sv -----
// ----------------------------------------------------------------------------
// sliding_mode_position_controller
// Sliding mode position law with boundary layer, Q15.16, microcoded datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries angle, velocity and target.
//   Output channel (out_valid/out_ready) carries one drive value per item.
//   Registers are written through cfg_wen/cfg_idx/cfg_data; the user must
//   do so only while idle, as the block itself does not enforce it;
//   indexes 6 and 7 are ignored.
// out_valid rises after the last step, or after step zero when the error
//   lies inside the deadband; a new item is taken only once the last one
//   has finished. The single 32 x 33 bit multiplier takes two passes for
//   each of the five gain products, stepped by a 12-word control store.
// Reset clears all configuration registers, the stored target and its
//   first difference, and empties the output register.
// A stalled receiver holds the result in the output register; the next item
//   is taken meanwhile and runs up to its last step, where it waits until
//   the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sliding_mode_position_controller (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_wen,
	input  logic [smpc_pkg::IDX_W-1:0]              cfg_idx,
	input  logic [smpc_pkg::GAIN_W-1:0]             cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [smpc_pkg::IN_W-1:0]        angle,
	input  logic signed [smpc_pkg::IN_W-1:0]        velocity,
	input  logic signed [smpc_pkg::IN_W-1:0]        target,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [smpc_pkg::OUT_W-1:0]       drive
);
	import smpc_pkg::*;

	// configuration registers
	logic [GAIN_W-1:0] slope_q, reach_q, switch_q, inertia_q, deadband_q, max_out_q;

	// control
	state_t          state_q, state_d;
	logic [PC_W-1:0] pc_q;
	ucode_t          uc;
	logic            in_xfer, run, dead, fin, slot_free, stall, step_en;
	logic            out_valid_q;

	// reference history
	logic signed [IN_W-1:0]    prev_target_q;
	logic signed [DELTA_W-1:0] prev_delta_q;
	logic signed [DELTA_W-1:0] delta;

	// datapath registers
	logic signed [ERR_W-1:0]   err_q;
	logic signed [VERR_W-1:0]  verr_q;
	logic signed [DDREF_W-1:0] ddref_q;
	logic signed [S_W-1:0]     s_q;
	logic signed [BR_W-1:0]    br_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [OUT_W-1:0]   drive_q;

	// datapath nets
	logic [GAIN_W-1:0]         gain;
	logic signed [BR_W-1:0]    opnd;
	logic signed [LIMB_W-1:0]  limb;
	logic signed [PROD_W-1:0]  prod;
	logic signed [ACC_W-1:0]   prod_x;
	logic signed [SH_W-1:0]    sh;
	logic signed [SAT_W-1:0]   sat;
	logic [ERR_W:0]            err_x, err_mag;
	logic signed [SH_W-1:0]    lim_hi, lim_lo;
	logic signed [OUT_W-1:0]   drive_d;

	// write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slope_q    <= '0;
			reach_q    <= '0;
			switch_q   <= '0;
			inertia_q  <= '0;
			deadband_q <= '0;
			max_out_q  <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				CFG_SLOPE:    slope_q    <= cfg_data;
				CFG_REACH:    reach_q    <= cfg_data;
				CFG_SWITCH:   switch_q   <= cfg_data;
				CFG_INERTIA:  inertia_q  <= cfg_data;
				CFG_DEADBAND: deadband_q <= cfg_data;
				CFG_MAX_OUT:  max_out_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// decode current step
	assign uc = ucode_rom(pc_q);

	// deadband test on |error|
	assign err_x   = {err_q[ERR_W-1], err_q};
	assign err_mag = err_x[ERR_W] ? (~err_x + 1'b1) : err_x;
	assign dead    = err_mag < {{(ERR_W+1-GAIN_W){1'b0}}, deadband_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_RUN;
			ST_RUN:  if (fin && slot_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		run       = (state_q == ST_RUN);
		in_xfer   = in_valid && in_ready;
		fin       = run && (uc.last || (uc.jmp == JMP_DEAD && dead));
		slot_free = !out_valid_q || out_ready;
		stall     = fin && !slot_free;
		step_en   = run && !stall;
	end

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				pc_q <= '0;
			end else if (step_en && !fin) begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

	// reference differences for the new item
	assign delta = DELTA_W'(target) - DELTA_W'(prev_target_q);

	// update reference history on every transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_target_q <= '0;
			prev_delta_q  <= '0;
		end else if (in_xfer) begin
			prev_target_q <= target;
			prev_delta_q  <= delta;
		end
	end

	// capture item terms
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			err_q   <= ERR_W'(angle) - ERR_W'(target);
			ddref_q <= DDREF_W'(delta) - DDREF_W'(prev_delta_q);
			verr_q  <= VERR_W'(velocity) - VERR_W'(delta);
		end
	end

	// boundary layer saturation of the surface
	always_comb begin
		priority if (s_q > S_W'(ONE_Q16)) begin
			sat = ONE_Q16;
		end else if (s_q < -S_W'(ONE_Q16)) begin
			sat = -ONE_Q16;
		end else begin
			sat = s_q[SAT_W-1:0];
		end
	end

	// select gain and operand
	always_comb begin
		unique case (uc.gain)
			G_SLOPE:   gain = slope_q;
			G_REACH:   gain = reach_q;
			G_SWITCH:  gain = switch_q;
			G_INERTIA: gain = inertia_q;
			default:   gain = slope_q;
		endcase
		unique case (uc.opnd)
			O_ERR:   opnd = BR_W'(err_q);
			O_VERR:  opnd = BR_W'(verr_q);
			O_S:     opnd = BR_W'(s_q);
			O_SAT:   opnd = BR_W'(sat);
			O_BR:    opnd = br_q;
			default: opnd = br_q;
		endcase
	end

	// shared multiplier: low limb unsigned, high limb signed
	assign limb   = (uc.mul == MUL_HI) ? opnd[BR_W-1:32] : {1'b0, opnd[31:0]};
	assign prod   = $signed({1'b0, gain}) * limb;
	assign prod_x = ACC_W'(prod);
	assign sh     = acc_q[ACC_W-1:16];

	// output clamp
	assign lim_hi = SH_W'($signed({1'b0, max_out_q}));
	assign lim_lo = -lim_hi;
	always_comb begin
		priority if (sh > lim_hi) begin
			drive_d = lim_hi[OUT_W-1:0];
		end else if (sh < lim_lo) begin
			drive_d = lim_lo[OUT_W-1:0];
		end else begin
			drive_d = sh[OUT_W-1:0];
		end
	end

	// accumulate products and write back results
	always_ff @(posedge clk) begin
		if (step_en) begin
			unique case (uc.mul)
				MUL_LO:   acc_q <= prod_x;
				MUL_HI:   acc_q <= acc_q + {prod_x[ACC_W-33:0], 32'b0};
				MUL_NONE: ;
				default:  ;
			endcase
			unique case (uc.wb)
				WB_S:       s_q  <= sh[S_W-1:0] + S_W'(verr_q);
				WB_BR_INIT: br_q <= BR_W'(ddref_q) - sh[BR_W-1:0];
				WB_BR_SUB:  br_q <= br_q - sh[BR_W-1:0];
				WB_NONE:    ;
				WB_DRIVE:   ;
				default:    ;
			endcase
		end
		if (fin && slot_free) begin
			drive_q <= dead && uc.jmp == JMP_DEAD ? '0 : drive_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	// checks
	`SMPC_ASSERT_NEXT(a_start_at_zero, in_valid && in_ready, state_q == ST_RUN && pc_q == '0, "item did not start at step zero")
	`SMPC_ASSERT_IMPL(a_pc_in_program, state_q == ST_RUN, pc_q <= LAST_PC, "step counter ran past the program")
	`SMPC_ASSERT_NEXT(a_finish_delivers, fin && slot_free, out_valid, "finished item not presented")

endmodule

// ----- tb/tb_sliding_mode_position_controller.sv -----
// ----------------------------------------------------------------------------
// tb_sliding_mode_position_controller
// Self-checking bench for the sliding mode position controller. A driver
// sends angle, velocity and target transfers from a queue, a monitor predicts
// each drive value at input transfer and compares it with the output
// transfers in order. Both channels idle at random, and the gains move
// through reset, hand-picked, extreme and random settings between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sliding_mode_position_controller;

	import smpc_pkg::*;

	typedef logic signed [127:0] acc_t;

	typedef struct {
		logic signed [IN_W-1:0] angle;
		logic signed [IN_W-1:0] velocity;
		logic signed [IN_W-1:0] target;
	} reading_t;

	// indexes past the register file, which the block must ignore
	localparam logic [IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	localparam logic signed [IN_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [IN_W-1:0] NEG_MAX = 32'sh8000_0000;
	localparam logic [GAIN_W-1:0]      GAIN_MAX = 31'h7FFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [IDX_W-1:0] cfg_idx = '0;
	logic [GAIN_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [IN_W-1:0] angle = '0;
	logic signed [IN_W-1:0] velocity = '0;
	logic signed [IN_W-1:0] target = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [OUT_W-1:0] drive;

	// register copies and controller state for the prediction
	logic [GAIN_W-1:0] slope_q, reach_q, switch_q, inertia_q, deadband_q, limit_q;
	logic signed [IN_W-1:0]    last_target;
	logic signed [DELTA_W-1:0] last_target_step;

	reading_t               pending_readings[$];
	logic signed [OUT_W-1:0] expected_drive[$];
	logic signed [IN_W-1:0] walk_target = '0;
	bit  in_taken = 1'b0;
	bit  steady = 1'b0;
	int  send_gap = 0;
	int  recv_stall = 0;
	int  mismatches = 0;

	sliding_mode_position_controller DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.angle     (angle),
		.velocity  (velocity),
		.target    (target),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.drive     (drive)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Q15.16 gain product, floor of the exact product
	function automatic acc_t gain_product(input logic [GAIN_W-1:0] g, input acc_t x);
		acc_t gw;
		gw = '0;
		gw[GAIN_W-1:0] = g;
		return (x * gw) >>> 16;
	endfunction

	// advance the target history and work out the clamped drive
	function automatic logic signed [OUT_W-1:0] compute_drive(
		input logic signed [IN_W-1:0] a_in,
		input logic signed [IN_W-1:0] v_in,
		input logic signed [IN_W-1:0] t_in
	);
		acc_t err, mag, step, curve, verr, surf, sat, bracket, out_w, lim, band, one;
		step = acc_t'(t_in) - acc_t'(last_target);
		curve = step - acc_t'(last_target_step);
		last_target_step = step[DELTA_W-1:0];
		last_target = t_in;
		err = acc_t'(a_in) - acc_t'(t_in);
		mag = (err < 0) ? -err : err;
		band = '0;
		band[GAIN_W-1:0] = deadband_q;
		if (mag < band)
			return '0;
		verr = acc_t'(v_in) - step;
		surf = gain_product(slope_q, err) + verr;
		one = 65536;
		if (surf > one)
			sat = one;
		else if (surf < -one)
			sat = -one;
		else
			sat = surf;
		bracket = curve - gain_product(slope_q, verr) - gain_product(switch_q, sat)
			- gain_product(reach_q, surf);
		out_w = gain_product(inertia_q, bracket);
		lim = '0;
		lim[GAIN_W-1:0] = limit_q;
		if (out_w > lim)
			out_w = lim;
		else if (out_w < -lim)
			out_w = -lim;
		return out_w[OUT_W-1:0];
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [GAIN_W-1:0] rand_gain(input int typical);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return GAIN_W'($urandom);
		if (r == 1)
			return '0;
		return GAIN_W'($urandom_range(0, typical));
	endfunction

	function automatic int spread(input int range);
		return int'($urandom_range(0, 2 * range)) - range;
	endfunction

	// mostly a smooth trajectory near the target, the rest full-range noise
	function automatic reading_t rand_reading();
		reading_t r;
		if ($urandom_range(0, 9) < 7) begin
			walk_target = walk_target + spread(1 << 17);
			r.target = walk_target;
			r.angle = walk_target + spread($urandom_range(0, 1) ? (1 << 14) : (1 << 20));
			r.velocity = spread(1 << 19);
		end else begin
			r.angle = $urandom;
			r.velocity = $urandom;
			r.target = $urandom;
		end
		return r;
	endfunction

	// input side: present queued readings, hold until transfer, then idle
	always @(negedge clk) begin : feed
		reading_t item;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
			// hold payload until transfer
		end else begin
			in_taken = 1'b0;
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (pending_readings.size() != 0) begin
				item = pending_readings.pop_front();
				angle <= item.angle;
				velocity <= item.velocity;
				target <= item.target;
				in_valid <= 1'b1;
				send_gap = steady ? 0 : pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side: random stalls of the receiver
	always @(negedge clk) begin
		if (recv_stall > 0) begin
			out_ready <= 1'b0;
			recv_stall--;
		end else begin
			out_ready <= 1'b1;
			if (!steady && $urandom_range(0, 3) == 0)
				recv_stall = pick_gap();
		end
	end

	// predict on input transfer, check on output transfer
	always @(posedge clk) begin : watch
		logic signed [OUT_W-1:0] want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_drive.push_back(compute_drive(angle, velocity, target));
				in_taken = 1'b1;
			end
			if (out_valid && out_ready) begin
				if (expected_drive.size() == 0) begin
					$error("drive: expected none, actual %0d", drive);
					mismatches++;
				end else begin
					want = expected_drive.pop_front();
					if (drive !== want) begin
						$error("drive: expected %0d, actual %0d", want, drive);
						mismatches++;
					end
				end
			end
		end
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			CFG_SLOPE:    slope_q = val;
			CFG_REACH:    reach_q = val;
			CFG_SWITCH:   switch_q = val;
			CFG_INERTIA:  inertia_q = val;
			CFG_DEADBAND: deadband_q = val;
			CFG_MAX_OUT:  limit_q = val;
			default:      ;
		endcase
	endtask

	task automatic send(input logic signed [IN_W-1:0] a, v, t);
		reading_t r;
		r.angle = a;
		r.velocity = v;
		r.target = t;
		pending_readings.push_back(r);
	endtask

	// wait until every transfer is done and the pipeline has drained
	task automatic settle();
		while (pending_readings.size() != 0 || in_valid || expected_drive.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	initial begin
		{slope_q, reach_q, switch_q, inertia_q, deadband_q, limit_q} = '0;
		last_target = '0;
		last_target_step = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// reset gains: zero clamp keeps the drive at zero
		send(32'sd0, 32'sd0, 32'sd0);
		send(POS_MAX, POS_MAX, NEG_MAX);
		send(NEG_MAX, NEG_MAX, POS_MAX);
		send(POS_MAX, NEG_MAX, POS_MAX);
		settle();

		// moderate gains, then writes to spare indexes that must not land
		write_reg(CFG_SLOPE, 31'd131072);
		write_reg(CFG_REACH, 31'd32768);
		write_reg(CFG_SWITCH, 31'd65536);
		write_reg(CFG_INERTIA, 31'd65536);
		write_reg(CFG_DEADBAND, 31'd6554);
		write_reg(CFG_MAX_OUT, 31'd6553600);
		write_reg(CFG_SPARE_LO, GAIN_MAX);
		write_reg(CFG_SPARE_HI, GAIN_MAX);
		// error on the deadband edge either way, then just inside
		send(32'sd7554, 32'sd0, 32'sd1000);
		send(-32'sd5554, 32'sd5, 32'sd1000);
		send(32'sd7553, 32'sd0, 32'sd1000);
		// large errors drive the clamp both ways
		send(-32'sd3276800, -32'sd1966080, 32'sd0);
		send(32'sd3276800, 32'sd1966080, 32'sd0);
		settle();

		// zero error and steady target: surface equals velocity
		write_reg(CFG_DEADBAND, '0);
		send(32'sd0, 32'sd0, 32'sd0);
		send(32'sd0, 32'sd65536, 32'sd0);
		send(32'sd0, -32'sd65536, 32'sd0);
		send(32'sd0, 32'sd65537, 32'sd0);
		settle();

		// every register at its top value, no idling
		steady = 1'b1;
		write_reg(CFG_SLOPE, GAIN_MAX);
		write_reg(CFG_REACH, GAIN_MAX);
		write_reg(CFG_SWITCH, GAIN_MAX);
		write_reg(CFG_INERTIA, GAIN_MAX);
		write_reg(CFG_DEADBAND, GAIN_MAX);
		write_reg(CFG_MAX_OUT, GAIN_MAX);
		send(POS_MAX, POS_MAX, NEG_MAX);
		send(NEG_MAX, NEG_MAX, POS_MAX);
		send(POS_MAX, NEG_MAX, NEG_MAX);
		send(NEG_MAX, POS_MAX, POS_MAX);
		settle();
		steady = 1'b0;

		// random gains per phase, random trajectories within
		for (int p = 0; p < 5; p++) begin
			steady = (p == 2);
			write_reg(CFG_SLOPE, rand_gain(4 << 16));
			write_reg(CFG_REACH, rand_gain(4 << 16));
			write_reg(CFG_SWITCH, rand_gain(4 << 16));
			write_reg(CFG_INERTIA, rand_gain(4 << 16));
			write_reg(CFG_DEADBAND, rand_gain(1 << 15));
			write_reg(CFG_MAX_OUT, (p == 4) ? '0 : rand_gain(200 << 16));
			if ($urandom_range(0, 1))
				write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
					GAIN_W'($urandom));
			for (int n = 0; n < 400; n++)
				pending_readings.push_back(rand_reading());
			settle();
		end
		steady = 1'b0;

		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// stop a hung run
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
